// ----- rtl/activation_forward_backward_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ACTIVATION_FORWARD_BACKWARD_MACROS_SVH
`define ACTIVATION_FORWARD_BACKWARD_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define AFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define AFB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

// ----- rtl/afb_pkg.sv -----
// ----------------------------------------------------------------------------
// Activation package
// Shared types, mode codes and the sigmoid table for the activation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package afb_pkg;
  localparam int DATA_W = 16;
  localparam int SIG_W = 17;
  localparam int STEP_SHIFT = 22;
  localparam int TABLE_LAST = 33;
  localparam logic [SIG_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [1:0] {
    MODE_IDENTITY = 2'd0,
    MODE_SIGMOID  = 2'd1,
    MODE_TANH     = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef enum logic {
    OP_FORWARD  = 1'b0,
    OP_BACKWARD = 1'b1
  } op_t;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] upstream_gradient;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic backward;
    logic is_sig;
    logic is_tanh;
    logic xneg;
    logic gneg;
  } ctrl_t;

  function automatic logic [SIG_W-1:0] sig_entry(input logic [5:0] k);
    logic [SIG_W-1:0] v;
    case (k)
      6'd0: v = 17'd32768;  6'd1: v = 17'd36843;  6'd2: v = 17'd40793;
      6'd3: v = 17'd44511;  6'd4: v = 17'd47911;  6'd5: v = 17'd50941;
      6'd6: v = 17'd53581;  6'd7: v = 17'd55834;  6'd8: v = 17'd57724;
      6'd9: v = 17'd59287;  6'd10: v = 17'd60565; 6'd11: v = 17'd61598;
      6'd12: v = 17'd62428; 6'd13: v = 17'd63090; 6'd14: v = 17'd63615;
      6'd15: v = 17'd64030; 6'd16: v = 17'd64357; 6'd17: v = 17'd64614;
      6'd18: v = 17'd64816; 6'd19: v = 17'd64974; 6'd20: v = 17'd65097;
      6'd21: v = 17'd65194; 6'd22: v = 17'd65269; 6'd23: v = 17'd65328;
      6'd24: v = 17'd65374; 6'd25: v = 17'd65410; 6'd26: v = 17'd65438;
      6'd27: v = 17'd65459; 6'd28: v = 17'd65476; 6'd29: v = 17'd65489;
      6'd30: v = 17'd65500; 6'd31: v = 17'd65508; 6'd32: v = 17'd65514;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction
endpackage

// ----- rtl/afb_interp.sv -----
// ----------------------------------------------------------------------------
// Sigmoid interpolation stages
// Table lookup in the first stage, linear interpolation in the second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module afb_interp #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  afb_pkg::request_t                    req,
  input  afb_pkg::mode_t                       mode,
  output logic                                 out_valid,
  output afb_pkg::ctrl_t                       out_ctrl,
  output logic [afb_pkg::SIG_W-1:0]            out_sig,
  output logic signed [afb_pkg::DATA_W-1:0]    out_x,
  output logic signed [afb_pkg::DATA_W-1:0]    out_g
);
  localparam int SH_U = 24 - FRAC_BITS;
  localparam int UW_RAW = afb_pkg::DATA_W + SH_U + 1;
  localparam int UW = (UW_RAW > 28) ? UW_RAW : 28;
  localparam int SW = afb_pkg::SIG_W;
  localparam int FW = afb_pkg::STEP_SHIFT;

  logic [afb_pkg::DATA_W-1:0] xmag;
  logic [UW-1:0]              u;
  logic [UW-FW-1:0]           idx;
  afb_pkg::ctrl_t             ctrl_next;

  logic                       v1;
  afb_pkg::ctrl_t             ctrl1;
  logic signed [afb_pkg::DATA_W-1:0] x1, g1;
  logic [SW-1:0]              lo1, hi1;
  logic [FW-1:0]              frac1;
  logic                       one1;
  logic [SW+FW-1:0]           prod;

  always_comb begin
    ctrl_next.backward = req.operation == afb_pkg::OP_BACKWARD;
    ctrl_next.is_sig = mode == afb_pkg::MODE_SIGMOID;
    ctrl_next.is_tanh = mode == afb_pkg::MODE_TANH;
    ctrl_next.xneg = req.x_value[afb_pkg::DATA_W-1];
    ctrl_next.gneg = req.upstream_gradient[afb_pkg::DATA_W-1];
    xmag = ctrl_next.xneg ? afb_pkg::DATA_W'(-req.x_value) : req.x_value;
    u = UW'(xmag) << SH_U;
    if (ctrl_next.is_tanh) begin
      u = u << 1;
    end
    idx = u[UW-1:FW];
  end

  assign prod = (SW+FW)'(hi1 - lo1) * (SW+FW)'(frac1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    ctrl1 <= ctrl_next;
    x1 <= req.x_value;
    g1 <= req.upstream_gradient;
    one1 <= idx >= (UW-FW)'(afb_pkg::TABLE_LAST);
    lo1 <= afb_pkg::sig_entry(idx[5:0]);
    hi1 <= afb_pkg::sig_entry(idx[5:0] + 6'd1);
    frac1 <= u[FW-1:0];
    out_ctrl <= ctrl1;
    out_x <= x1;
    out_g <= g1;
    out_sig <= one1 ? afb_pkg::ONE_Q16 : lo1 + SW'(prod >> FW);
  end
endmodule

// ----- rtl/afb_post.sv -----
// ----------------------------------------------------------------------------
// Activation output stages
// Forms f(x) or the derivative times the gradient, rounds, clips; identity passes x or the gradient through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module afb_post #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  afb_pkg::ctrl_t                    in_ctrl,
  input  logic [afb_pkg::SIG_W-1:0]         in_sig,
  input  logic signed [afb_pkg::DATA_W-1:0] in_x,
  input  logic signed [afb_pkg::DATA_W-1:0] in_g,
  output logic                              out_valid,
  output afb_pkg::result_t                  out_result
);
  localparam int SW = afb_pkg::SIG_W;
  localparam int DW = afb_pkg::DATA_W;
  localparam int MW = SW + 24;
  localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int RND = (FRAC_BITS < 16) ? (1 << (15 - FRAC_BITS)) : 0;
  localparam int DFW = 33;
  localparam int PW = DW + DFW;
  localparam logic [MW-1:0] POS_MAX = MW'((1 << (DW - 1)) - 1);
  localparam logic [MW-1:0] NEG_MAX = MW'(1 << (DW - 1));

  logic [SW-1:0]  t, fv;
  logic [MW-1:0]  fmag_next;
  logic [2*SW-1:0] sq;
  logic [DFW-1:0] d_next;

  logic           v3, v4;
  afb_pkg::ctrl_t ctrl3, ctrl4;
  logic [MW-1:0]  fmag3, fmag4;
  logic [DFW-1:0] d3;
  logic signed [DW-1:0] x3, g3, x4, g4;
  logic [PW-1:0]  p4;
  logic [DW-1:0]  gmag;

  logic [MW-1:0]  mag;
  logic           neg, clip;
  logic signed [DW-1:0] r;

  always_comb begin
    t = in_ctrl.is_tanh ? SW'({in_sig, 1'b0} - {1'b0, afb_pkg::ONE_Q16}) : in_sig;
    if (in_ctrl.is_sig && in_ctrl.xneg) begin
      fv = afb_pkg::ONE_Q16 - in_sig;
    end else begin
      fv = t;
    end
    if (FRAC_BITS >= 16) begin
      fmag_next = MW'(fv) << SH_L;
    end else begin
      fmag_next = (MW'(fv) + MW'(RND)) >> SH_R;
    end
    if (in_ctrl.is_tanh) begin
      sq = t * t;
      d_next = (DFW'(1) << 32) - DFW'(sq);
    end else begin
      sq = in_sig * (afb_pkg::ONE_Q16 - in_sig);
      d_next = DFW'(sq);
    end
  end

  assign gmag = g3[DW-1] ? DW'(-g3) : g3;

  always_comb begin
    if (ctrl4.backward) begin
      mag = MW'((p4 + (PW'(1) << 31)) >> 32);
      neg = ctrl4.gneg;
    end else begin
      mag = fmag4;
      neg = ctrl4.is_tanh && ctrl4.xneg;
    end
    clip = 1'b0;
    if (!ctrl4.is_sig && !ctrl4.is_tanh) begin
      r = ctrl4.backward ? g4 : x4;
    end else if (!neg && mag > POS_MAX) begin
      r = DW'(POS_MAX);
      clip = 1'b1;
    end else if (neg && mag > NEG_MAX) begin
      r = DW'(NEG_MAX);
      clip = 1'b1;
    end else begin
      r = neg ? DW'(-mag) : DW'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v3 <= in_valid;
      v4 <= v3;
      out_valid <= v4;
    end
    ctrl3 <= in_ctrl;
    fmag3 <= fmag_next;
    d3 <= d_next;
    x3 <= in_x;
    g3 <= in_g;
    ctrl4 <= ctrl3;
    fmag4 <= fmag3;
    x4 <= x3;
    g4 <= g3;
    p4 <= PW'(gmag) * PW'(d3);
    out_result.result_value <= r;
    out_result.saturated <= clip;
  end
endmodule

// ----- rtl/activation_forward_backward.sv -----
// ----------------------------------------------------------------------------
// Activation forward/backward unit
// Identity, sigmoid or tanh and their gradients in signed Q4.12.
// ----------------------------------------------------------------------------
// A request is taken at every clock edge where start is high; busy is always
// low, so one request can enter in every cycle.
// Each request gives one result on result, marked by done for one cycle.
// The result passes the five register stages of the pipeline: two in afb_interp
// and three in afb_post.
// Throughput is one result per cycle through the five pipeline stages.
// The mode register is written through cfg_we and cfg_data and applies to
// requests taken after the write.
// Reset clears the mode to identity and drops every request in flight.
// The receiver cannot hold results off; done is a plain strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module activation_forward_backward #(
  parameter int FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  afb_pkg::request_t request,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  output logic              done,
  output afb_pkg::result_t  result
);
  afb_pkg::mode_t mode;
  logic           iv;
  afb_pkg::ctrl_t ictrl;
  logic [afb_pkg::SIG_W-1:0] isig;
  logic signed [afb_pkg::DATA_W-1:0] ix, ig;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= afb_pkg::MODE_IDENTITY;
    end else if (cfg_we) begin
      mode <= afb_pkg::mode_t'(cfg_data);
    end
  end

  afb_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .req(request), .mode(mode),
    .out_valid(iv), .out_ctrl(ictrl), .out_sig(isig), .out_x(ix), .out_g(ig)
  );

  afb_post #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk(clk), .rst(rst), .in_valid(iv), .in_ctrl(ictrl), .in_sig(isig),
    .in_x(ix), .in_g(ig), .out_valid(done), .out_result(result)
  );
endmodule

// ----- rtl/afb_checker.sv -----
// ----------------------------------------------------------------------------
// Activation unit checker
// Port-level checks on busy, latency and clipping, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "activation_forward_backward_macros.svh"
module afb_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input afb_pkg::result_t result
);
  `AFB_NEVER(a_never_busy, busy, "busy was raised")
  `AFB_ASSERT(a_done_source, done |-> $past(start, 5), "result without a request")
  `AFB_ASSERT(a_clip_value, done && result.saturated |-> result.result_value == 16'sh7fff || result.result_value == 16'sh8000, "clipped result off the range limit")
endmodule

bind activation_forward_backward afb_checker u_afb_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Activation unit testbench
// Drives forward and backward requests through every activation mode, predicts
// each result with an independent fixed-point model and checks every strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  localparam int FRAC = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  afb_pkg::request_t request = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic done;
  afb_pkg::result_t result;

  afb_pkg::mode_t active_mode = afb_pkg::MODE_IDENTITY;
  afb_pkg::result_t expected_results[$];
  int error_count = 0;
  bit steady = 1'b0;

  activation_forward_backward #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [31:0] sigmoid_lookup(input logic [47:0] mag24);
    logic [47:0] idx;
    logic [47:0] frac;
    logic [31:0] lo_v;
    logic [31:0] hi_v;
    logic [31:0] table_v[0:33];
    table_v = '{32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
                57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
                64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
                65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
                65514, 65536};
    idx = mag24 >> 22;
    frac = mag24 & ((48'd1 << 22) - 1);
    if (idx >= 33) return 32'd65536;
    lo_v = table_v[idx];
    hi_v = table_v[idx + 1];
    return lo_v + 32'((64'(hi_v - lo_v) * 64'(frac)) >> 22);
  endfunction

  function automatic longint q16_round(input longint v);
    return (v + (64'd1 << (15 - FRAC))) >>> (16 - FRAC);
  endfunction

  function automatic afb_pkg::result_t activation_predict(input afb_pkg::mode_t mode,
                                                          input afb_pkg::request_t req);
    afb_pkg::result_t res;
    longint x;
    longint g;
    longint r;
    logic [47:0] mag24;
    longint s;
    longint t;
    logic [63:0] d;
    logic [63:0] gm;
    logic [63:0] p;
    bit is_tanh;
    x = longint'(req.x_value);
    g = longint'(req.upstream_gradient);
    res.saturated = 1'b0;
    if (mode == afb_pkg::MODE_SIGMOID || mode == afb_pkg::MODE_TANH) begin
      is_tanh = (mode == afb_pkg::MODE_TANH);
      mag24 = 48'(x < 0 ? -x : x) << (24 - FRAC);
      s = sigmoid_lookup(is_tanh ? mag24 << 1 : mag24);
      t = is_tanh ? s * 2 - 65536 : s;
      if (req.operation == afb_pkg::OP_FORWARD) begin
        if (is_tanh) r = (x < 0) ? -q16_round(t) : q16_round(t);
        else r = q16_round(x < 0 ? 65536 - s : s);
      end else begin
        d = is_tanh ? 64'(65536 * 65536 - t * t) : 64'(s * (65536 - s));
        gm = 64'(g < 0 ? -g : g);
        p = gm * d;
        r = longint'((p + (64'd1 << 31)) >> 32);
        if (g < 0) r = -r;
      end
      if (r > 32767) begin
        r = 32767;
        res.saturated = 1'b1;
      end else if (r < -32768) begin
        r = -32768;
        res.saturated = 1'b1;
      end
    end else begin
      r = (req.operation == afb_pkg::OP_BACKWARD) ? g : x;
    end
    res.result_value = r[15:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    afb_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result.result_value, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.result_value !== want.result_value)
          report_mismatch("result_value", result.result_value, want.result_value);
        if (result.saturated !== want.saturated)
          report_mismatch("saturated", result.saturated, want.saturated);
      end
    end
  end

  task automatic idle_gap();
    int n;
    if (!steady && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_request(input afb_pkg::op_t op, input logic [15:0] x,
                              input logic [15:0] g);
    afb_pkg::request_t req;
    req.operation = op;
    req.x_value = x;
    req.upstream_gradient = g;
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(activation_predict(active_mode, req));
    idle_gap();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (expected_results.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input afb_pkg::mode_t mode);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_mode = (mode == afb_pkg::MODE_SPARE) ? afb_pkg::MODE_IDENTITY : mode;
  endtask

  task automatic test_directed_mode(input afb_pkg::mode_t mode);
    logic [15:0] xs[9];
    set_mode(mode);
    xs = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
           16'h1000, 16'hf000, 16'h4000, 16'h2100};
    foreach (xs[i]) send_request(afb_pkg::OP_FORWARD, xs[i], 16'($urandom));
    send_request(afb_pkg::OP_BACKWARD, 16'h0000, 16'h7fff);
    send_request(afb_pkg::OP_BACKWARD, 16'h0000, 16'h8000);
    send_request(afb_pkg::OP_BACKWARD, 16'h8000, 16'h7fff);
    send_request(afb_pkg::OP_BACKWARD, 16'h1000, 16'hffff);
  endtask

  task automatic test_random_mode(input afb_pkg::mode_t mode, input int count);
    logic [15:0] x;
    set_mode(mode);
    for (int i = 0; i < count; i++) begin
      x = 16'($urandom);
      if ($urandom_range(0, 1)) x = 16'($signed(x) >>> $urandom_range(0, 3));
      send_request(afb_pkg::op_t'($urandom_range(0, 1)), x, 16'($urandom));
    end
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    test_random_mode(afb_pkg::MODE_TANH, 60);
    test_random_mode(afb_pkg::MODE_SIGMOID, 40);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_mode(afb_pkg::MODE_SIGMOID);
    test_directed_mode(afb_pkg::MODE_TANH);
    test_directed_mode(afb_pkg::MODE_IDENTITY);
    test_directed_mode(afb_pkg::MODE_SPARE);
    test_random_mode(afb_pkg::MODE_SIGMOID, 100);
    test_random_mode(afb_pkg::MODE_TANH, 100);
    test_random_mode(afb_pkg::MODE_IDENTITY, 40);
    test_back_to_back();
    drain();
    if (expected_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
